// File: rtl/lwg_pkg.sv
`timescale 1ns / 1ps

package lwg_pkg;

    typedef struct packed {
        logic [6:0] col_offset;
        logic [6:0] row_offset;
    } t_cfg;

    typedef logic [0:11][7:0] t_glyph;

    localparam logic [1:0] MODE_WINDOW = 2'd0;
    localparam logic [1:0] MODE_PIXEL  = 2'd1;
    localparam logic [1:0] MODE_GLYPH  = 2'd2;
    localparam logic [1:0] MODE_NONE   = 2'd3;

    localparam logic [7:0] CMD_CASET = 8'h2A;
    localparam logic [7:0] CMD_RASET = 8'h2B;
    localparam logic [7:0] CMD_RAMWR = 8'h2C;

    localparam logic [6:0] COL_OFFSET_RST = 7'd0;
    localparam logic [6:0] ROW_OFFSET_RST = 7'd80;

    localparam logic       REG_COL_OFFSET = 1'b0;
    localparam logic       REG_ROW_OFFSET = 1'b1;

    localparam logic [7:0] FONT_FIRST = 8'd32;
    localparam logic [7:0] FONT_LAST  = 8'd89;
    localparam logic [4:0] FONT_DEPTH = 5'd12;

    localparam logic [3:0] LAST_WINDOW = 4'd10;
    localparam logic [3:0] LAST_PIXEL  = 4'd1;
    localparam logic [3:0] LAST_GLYPH  = 4'd15;

    function automatic t_glyph font_glyph(input logic [5:0] idx);
        t_glyph g;
        g = '0;
        case (idx)
            6'd11: g = {8'h00,8'h00,8'h18,8'h18,8'h18,8'hFF,8'hFF,8'h18,8'h18,8'h18,8'h00,8'h00};
            6'd13: g = {8'h00,8'h00,8'h00,8'h00,8'h00,8'h7E,8'h7E,8'h00,8'h00,8'h00,8'h00,8'h00};
            6'd14: g = {8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h30,8'h30,8'h00};
            6'd15: g = {8'h00,8'h06,8'h0C,8'h18,8'h30,8'h60,8'hC0,8'h80,8'h00,8'h00,8'h00,8'h00};
            6'd16: g = {8'h3C,8'h66,8'h6E,8'h7E,8'h76,8'h66,8'h66,8'h66,8'h66,8'h3C,8'h00,8'h00};
            6'd17: g = {8'h18,8'h38,8'h18,8'h18,8'h18,8'h18,8'h18,8'h18,8'h18,8'h7E,8'h00,8'h00};
            6'd18: g = {8'h3C,8'h66,8'h06,8'h06,8'h0C,8'h18,8'h30,8'h60,8'h66,8'h7E,8'h00,8'h00};
            6'd19: g = {8'h3C,8'h66,8'h06,8'h06,8'h1C,8'h06,8'h06,8'h06,8'h66,8'h3C,8'h00,8'h00};
            6'd20: g = {8'h0C,8'h1C,8'h3C,8'h6C,8'hCC,8'hFE,8'h0C,8'h0C,8'h0C,8'h1E,8'h00,8'h00};
            6'd21: g = {8'h7E,8'h60,8'h60,8'h7C,8'h66,8'h06,8'h06,8'h06,8'h66,8'h3C,8'h00,8'h00};
            6'd22: g = {8'h3C,8'h66,8'h60,8'h7C,8'h66,8'h66,8'h66,8'h66,8'h66,8'h3C,8'h00,8'h00};
            6'd23: g = {8'h7E,8'h66,8'h06,8'h0C,8'h18,8'h18,8'h30,8'h30,8'h30,8'h30,8'h00,8'h00};
            6'd24: g = {8'h3C,8'h66,8'h66,8'h66,8'h3C,8'h66,8'h66,8'h66,8'h66,8'h3C,8'h00,8'h00};
            6'd25: g = {8'h3C,8'h66,8'h66,8'h66,8'h66,8'h3E,8'h06,8'h06,8'h66,8'h3C,8'h00,8'h00};
            6'd26: g = {8'h00,8'h00,8'h00,8'h30,8'h30,8'h00,8'h00,8'h30,8'h30,8'h00,8'h00,8'h00};
            6'd33: g = {8'h18,8'h3C,8'h66,8'h66,8'h66,8'h7E,8'h66,8'h66,8'h66,8'h66,8'h00,8'h00};
            6'd34: g = {8'h7C,8'h66,8'h66,8'h66,8'h7C,8'h66,8'h66,8'h66,8'h66,8'h7C,8'h00,8'h00};
            6'd35: g = {8'h3C,8'h66,8'h60,8'h60,8'h60,8'h60,8'h60,8'h60,8'h66,8'h3C,8'h00,8'h00};
            6'd36: g = {8'h78,8'h6C,8'h66,8'h66,8'h66,8'h66,8'h66,8'h66,8'h6C,8'h78,8'h00,8'h00};
            6'd37: g = {8'h7E,8'h60,8'h60,8'h60,8'h7C,8'h60,8'h60,8'h60,8'h60,8'h7E,8'h00,8'h00};
            6'd38: g = {8'h7E,8'h60,8'h60,8'h60,8'h7C,8'h60,8'h60,8'h60,8'h60,8'h60,8'h00,8'h00};
            6'd39: g = {8'h3C,8'h66,8'h60,8'h60,8'h6E,8'h66,8'h66,8'h66,8'h66,8'h3C,8'h00,8'h00};
            6'd40: g = {8'h66,8'h66,8'h66,8'h66,8'h7E,8'h66,8'h66,8'h66,8'h66,8'h66,8'h00,8'h00};
            6'd41: g = {8'h3C,8'h18,8'h18,8'h18,8'h18,8'h18,8'h18,8'h18,8'h18,8'h3C,8'h00,8'h00};
            6'd45: g = {8'h63,8'h77,8'h7F,8'h6B,8'h63,8'h63,8'h63,8'h63,8'h63,8'h63,8'h00,8'h00};
            6'd46: g = {8'h66,8'h76,8'h7E,8'h7E,8'h6E,8'h66,8'h66,8'h66,8'h66,8'h66,8'h00,8'h00};
            6'd47: g = {8'h3C,8'h66,8'h66,8'h66,8'h66,8'h66,8'h66,8'h66,8'h66,8'h3C,8'h00,8'h00};
            6'd48: g = {8'h7C,8'h66,8'h66,8'h66,8'h7C,8'h60,8'h60,8'h60,8'h60,8'h60,8'h00,8'h00};
            6'd50: g = {8'h7C,8'h66,8'h66,8'h66,8'h7C,8'h6E,8'h66,8'h66,8'h66,8'h66,8'h00,8'h00};
            6'd51: g = {8'h3C,8'h66,8'h60,8'h30,8'h1C,8'h06,8'h06,8'h06,8'h66,8'h3C,8'h00,8'h00};
            6'd52: g = {8'h7E,8'h5A,8'h18,8'h18,8'h18,8'h18,8'h18,8'h18,8'h18,8'h3C,8'h00,8'h00};
            6'd53: g = {8'h66,8'h66,8'h66,8'h66,8'h66,8'h66,8'h66,8'h66,8'h66,8'h3C,8'h00,8'h00};
            6'd54: g = {8'h66,8'h66,8'h66,8'h66,8'h66,8'h66,8'h3C,8'h3C,8'h18,8'h18,8'h00,8'h00};
            6'd55: g = {8'h63,8'h63,8'h63,8'h63,8'h6B,8'h6B,8'h7F,8'h36,8'h36,8'h22,8'h00,8'h00};
            6'd57: g = {8'h66,8'h66,8'h66,8'h66,8'h3C,8'h18,8'h18,8'h18,8'h18,8'h3C,8'h00,8'h00};
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

// File: rtl/lwg_font_rom.sv
`timescale 1ns / 1ps

module lwg_font_rom #(
    parameter int GLYPH_ROWS = 12
) (
    input  logic       i_clk,
    input  logic       i_en,
    input  logic [7:0] i_char_code,
    input  logic [3:0] i_glyph_row,
    output logic [7:0] o_bits
);

    localparam logic [4:0] ROWS_LIM = 5'(GLYPH_ROWS);

    logic [7:0]           r_bits;
    logic [7:0]           n_bits;
    logic [7:0]           code_ofs;
    logic                 hit;
    lwg_pkg::t_glyph      glyph;

    always_comb begin
        code_ofs = i_char_code - lwg_pkg::FONT_FIRST;
        glyph    = lwg_pkg::font_glyph(code_ofs[5:0]);
        hit      = (i_char_code >= lwg_pkg::FONT_FIRST) &&
                   (i_char_code <= lwg_pkg::FONT_LAST) &&
                   ({1'b0, i_glyph_row} < ROWS_LIM) &&
                   ({1'b0, i_glyph_row} < lwg_pkg::FONT_DEPTH);
        n_bits   = hit ? glyph[i_glyph_row] : 8'h00;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_bits <= n_bits;
        end
    end

    assign o_bits = r_bits;

endmodule

// File: rtl/lwg_regs.sv
`timescale 1ns / 1ps

module lwg_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output lwg_pkg::t_cfg       o_cfg
);

    logic [6:0] r_col_offset;
    logic [6:0] r_row_offset;
    logic       wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_offset <= lwg_pkg::COL_OFFSET_RST;
            r_row_offset <= lwg_pkg::ROW_OFFSET_RST;
        end else if (wr_en) begin
            case (paddr[2])
                lwg_pkg::REG_COL_OFFSET: r_col_offset <= pwdata[6:0];
                lwg_pkg::REG_ROW_OFFSET: r_row_offset <= pwdata[6:0];
                default: r_col_offset <= r_col_offset;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            lwg_pkg::REG_COL_OFFSET: prdata = {25'd0, r_col_offset};
            lwg_pkg::REG_ROW_OFFSET: prdata = {25'd0, r_row_offset};
            default:                 prdata = 32'd0;
        endcase
    end

    assign o_cfg.col_offset = r_col_offset;
    assign o_cfg.row_offset = r_row_offset;

endmodule

// File: rtl/lwg_seq.sv
`timescale 1ns / 1ps

module lwg_seq #(
    parameter int PANEL_SIZE = 240,
    parameter int GLYPH_ROWS = 12
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  lwg_pkg::t_cfg i_cfg,
    input  logic          start,
    output logic          busy,
    input  logic [1:0]    i_mode,
    input  logic [7:0]    i_x,
    input  logic [7:0]    i_y,
    input  logic [7:0]    i_w,
    input  logic [7:0]    i_h,
    input  logic [15:0]   i_color,
    input  logic [15:0]   i_bg_color,
    input  logic [7:0]    i_char_code,
    input  logic [3:0]    i_glyph_row,
    input  logic          i_end_frame,
    output logic          o_strobe,
    output logic          o_is_data,
    output logic [7:0]    o_word_byte,
    output logic          o_cs_release,
    output logic          o_last
);

    localparam logic [8:0] PANEL_LIM = 9'(PANEL_SIZE);
    localparam logic [7:0] PANEL_END = 8'(PANEL_SIZE - 1);

    localparam logic [3:0] W_CASET = 4'd0;
    localparam logic [3:0] W_XS_HI = 4'd1;
    localparam logic [3:0] W_XS_LO = 4'd2;
    localparam logic [3:0] W_XE_HI = 4'd3;
    localparam logic [3:0] W_XE_LO = 4'd4;
    localparam logic [3:0] W_RASET = 4'd5;
    localparam logic [3:0] W_YS_HI = 4'd6;
    localparam logic [3:0] W_YS_LO = 4'd7;
    localparam logic [3:0] W_YE_HI = 4'd8;
    localparam logic [3:0] W_YE_LO = 4'd9;
    localparam logic [3:0] W_RAMWR = 4'd10;

    logic        accept;
    logic        r_active;
    logic [3:0]  r_idx;
    logic [3:0]  r_last_idx;
    logic [1:0]  r_mode;
    logic        r_end_frame;
    logic [15:0] r_color;
    logic [15:0] r_bg_color;
    logic [8:0]  r_xs;
    logic [8:0]  r_xe;
    logic [8:0]  r_ys;
    logic [8:0]  r_ye;
    logic        r_strobe;
    logic        r_is_data;
    logic [7:0]  r_word_byte;
    logic        r_cs_release;
    logic        r_last;

    logic        n_is_data;
    logic [7:0]  n_word_byte;
    logic        n_cs_release;
    logic        n_last;
    logic [3:0]  n_last_idx;
    logic [8:0]  sum_x;
    logic [8:0]  sum_y;
    logic [8:0]  dec_x;
    logic [8:0]  dec_y;
    logic [7:0]  end_x;
    logic [7:0]  end_y;
    logic [8:0]  n_xs;
    logic [8:0]  n_xe;
    logic [8:0]  n_ys;
    logic [8:0]  n_ye;
    logic [7:0]  glyph_bits;
    logic [2:0]  pix;
    logic [15:0] pix_color;

    assign busy   = r_active && (r_idx != r_last_idx);
    assign accept = start && !busy;

    lwg_font_rom #(
        .GLYPH_ROWS (GLYPH_ROWS)
    ) u_font_rom (
        .i_clk       (i_clk),
        .i_en        (accept),
        .i_char_code (i_char_code),
        .i_glyph_row (i_glyph_row),
        .o_bits      (glyph_bits)
    );

    // window bounds, clamped end then offset
    always_comb begin
        sum_x = {1'b0, i_x} + {1'b0, i_w};
        sum_y = {1'b0, i_y} + {1'b0, i_h};
        dec_x = sum_x - 9'd1;
        dec_y = sum_y - 9'd1;
        end_x = ((sum_x == 9'd0) || (sum_x > PANEL_LIM)) ? PANEL_END : dec_x[7:0];
        end_y = ((sum_y == 9'd0) || (sum_y > PANEL_LIM)) ? PANEL_END : dec_y[7:0];
        n_xs  = {1'b0, i_x} + {2'b00, i_cfg.col_offset};
        n_xe  = {1'b0, end_x} + {2'b00, i_cfg.col_offset};
        n_ys  = {1'b0, i_y} + {2'b00, i_cfg.row_offset};
        n_ye  = {1'b0, end_y} + {2'b00, i_cfg.row_offset};
        case (i_mode)
            lwg_pkg::MODE_WINDOW: n_last_idx = lwg_pkg::LAST_WINDOW;
            lwg_pkg::MODE_PIXEL:  n_last_idx = lwg_pkg::LAST_PIXEL;
            lwg_pkg::MODE_GLYPH:  n_last_idx = lwg_pkg::LAST_GLYPH;
            default:              n_last_idx = lwg_pkg::LAST_PIXEL;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_idx    <= 4'd0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_active;
            if (accept) begin
                r_active <= (i_mode != lwg_pkg::MODE_NONE);
                r_idx    <= 4'd0;
            end else if (r_active) begin
                if (r_idx == r_last_idx) begin
                    r_active <= 1'b0;
                end else begin
                    r_idx <= r_idx + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_last_idx  <= n_last_idx;
            r_mode      <= i_mode;
            r_end_frame <= i_end_frame;
            r_color     <= i_color;
            r_bg_color  <= i_bg_color;
            r_xs        <= n_xs;
            r_xe        <= n_xe;
            r_ys        <= n_ys;
            r_ye        <= n_ye;
        end
        r_is_data    <= n_is_data;
        r_word_byte  <= n_word_byte;
        r_cs_release <= n_cs_release;
        r_last       <= n_last;
    end

    always_comb begin
        pix          = r_idx[3:1];
        pix_color    = glyph_bits[3'd7 - pix] ? r_color : r_bg_color;
        n_last       = r_active && (r_idx == r_last_idx);
        n_is_data    = 1'b1;
        n_word_byte  = 8'h00;
        n_cs_release = 1'b0;
        case (r_mode)
            lwg_pkg::MODE_WINDOW: begin
                n_cs_release = 1'b1;
                case (r_idx)
                    W_CASET: begin
                        n_is_data   = 1'b0;
                        n_word_byte = lwg_pkg::CMD_CASET;
                    end
                    W_XS_HI: n_word_byte = {7'd0, r_xs[8]};
                    W_XS_LO: n_word_byte = r_xs[7:0];
                    W_XE_HI: n_word_byte = {7'd0, r_xe[8]};
                    W_XE_LO: n_word_byte = r_xe[7:0];
                    W_RASET: begin
                        n_is_data   = 1'b0;
                        n_word_byte = lwg_pkg::CMD_RASET;
                    end
                    W_YS_HI: n_word_byte = {7'd0, r_ys[8]};
                    W_YS_LO: n_word_byte = r_ys[7:0];
                    W_YE_HI: n_word_byte = {7'd0, r_ye[8]};
                    W_YE_LO: n_word_byte = r_ye[7:0];
                    W_RAMWR: begin
                        n_is_data   = 1'b0;
                        n_word_byte = lwg_pkg::CMD_RAMWR;
                    end
                    default: n_word_byte = 8'h00;
                endcase
            end
            lwg_pkg::MODE_PIXEL: begin
                n_word_byte  = r_idx[0] ? r_color[7:0] : r_color[15:8];
                n_cs_release = n_last && r_end_frame;
            end
            lwg_pkg::MODE_GLYPH: begin
                n_word_byte  = r_idx[0] ? pix_color[7:0] : pix_color[15:8];
                n_cs_release = n_last && r_end_frame;
            end
            default: n_word_byte = 8'h00;
        endcase
    end

    assign o_strobe     = r_strobe;
    assign o_is_data    = r_is_data;
    assign o_word_byte  = r_word_byte;
    assign o_cs_release = r_cs_release;
    assign o_last       = r_last;

    a_last_needs_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_last |-> r_strobe)
        else $error("last flag without word strobe");

    a_first_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_mode != lwg_pkg::MODE_NONE)) |-> ##2 r_strobe)
        else $error("first word missing two cycles after transfer");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_idx <= r_last_idx))
        else $error("word index past end of burst");

    a_burst_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active && (r_idx == r_last_idx)) |=> (r_strobe && r_last))
        else $error("burst end not marked last");

endmodule

// File: rtl/lcd_window_pixel_glyph_word_generator.sv
`timescale 1ns / 1ps
// The first word goes through the sequencer state register, loaded with the font ROM read,
// and then the output register. Throughput: one word per cycle; 11 words per window item,
// 2 per pixel, 16 per glyph row; the next item is taken during the last word's cycle, so
// bursts run gap-free. A mode 3 item is taken and produces no word.
// Reset (synchronous, active low): sequencer idle, column offset 0, row offset 80.
// Words cannot be stalled by the receiver: each is valid for exactly one cycle.

module lcd_window_pixel_glyph_word_generator #(
    parameter int PANEL_SIZE = 240,
    parameter int GLYPH_ROWS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_x,
    input  logic [7:0]  i_y,
    input  logic [7:0]  i_w,
    input  logic [7:0]  i_h,
    input  logic [15:0] i_color,
    input  logic [15:0] i_bg_color,
    input  logic [7:0]  i_char_code,
    input  logic [3:0]  i_glyph_row,
    input  logic        i_end_frame,
    output logic        o_strobe,
    output logic        o_is_data,
    output logic [7:0]  o_word_byte,
    output logic        o_cs_release,
    output logic        o_last
);

    lwg_pkg::t_cfg cfg;

    lwg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    lwg_seq #(
        .PANEL_SIZE (PANEL_SIZE),
        .GLYPH_ROWS (GLYPH_ROWS)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .start        (start),
        .busy         (busy),
        .i_mode       (i_mode),
        .i_x          (i_x),
        .i_y          (i_y),
        .i_w          (i_w),
        .i_h          (i_h),
        .i_color      (i_color),
        .i_bg_color   (i_bg_color),
        .i_char_code  (i_char_code),
        .i_glyph_row  (i_glyph_row),
        .i_end_frame  (i_end_frame),
        .o_strobe     (o_strobe),
        .o_is_data    (o_is_data),
        .o_word_byte  (o_word_byte),
        .o_cs_release (o_cs_release),
        .o_last       (o_last)
    );

endmodule
